@@ rtl/tpls_pkg.sv @@
// shared types and constants of the track parameter layer store
// word layouts, operation and status codes, reset layout values; no dependencies
package tpls_pkg;

  localparam int STEP_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int TRACK_W = 4;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 3;

  localparam logic [KIND_W-1:0] KIND_INIT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK             = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_LAYOUT     = 3'd1;
  localparam logic [STAT_W-1:0] ST_BAD_INSTRUMENT = 3'd2;
  localparam logic [STAT_W-1:0] ST_BAD_LAYER      = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD_STEP       = 3'd4;

  localparam logic [STEP_W-1:0] RESET_STEPS       = 16'd128;
  localparam logic [BYTE_W-1:0] RESET_LAYERS      = 8'd8;
  localparam logic [BYTE_W-1:0] RESET_INSTRUMENTS = 8'd1;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [TRACK_W-1:0] track;
    logic [STEP_W-1:0]  step_number;
    logic [BYTE_W-1:0]  layer_index;
    logic [BYTE_W-1:0]  instrument_index;
    logic [BYTE_W-1:0]  write_value;
    logic [STEP_W-1:0]  layout_steps;
    logic [BYTE_W-1:0]  layout_layers;
    logic [BYTE_W-1:0]  layout_instruments;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic [STAT_W-1:0] status;
  } result_t;

endpackage

@@ rtl/tpls_mod_unit.sv @@
// iterative step remainder unit, one quotient bit per cycle
// depends on tpls_pkg for the step width
module tpls_mod_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tpls_pkg::STEP_W-1:0]  dividend,
  input  logic [tpls_pkg::STEP_W-1:0]  divisor,
  output logic                         done,
  output logic [tpls_pkg::STEP_W-1:0]  remainder
);

  localparam int W  = tpls_pkg::STEP_W;
  localparam int CW = $clog2(W);

  logic          busy;
  logic [CW-1:0] count;
  logic [W-1:0]  num;
  logic [W-1:0]  den;
  logic [W-1:0]  rem;
  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic [W-1:0]  rem_next;

  assign shifted   = {rem, num[W-1]};
  assign diff      = shifted - {1'b0, den};
  assign rem_next  = diff[W] ? shifted[W-1:0] : diff[W-1:0];
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      den <= divisor;
      rem <= '0;
    end else if (busy) begin
      num <= {num[W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

endmodule

@@ rtl/tpls_value_mem.sv @@
// single port byte memory holding every track's values, registered read
// no dependencies
module tpls_value_mem #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/track_parameter_layer_store_top.sv @@
// top level of the track parameter layer store: sequencer, layout tables, result register
// depends on tpls_pkg, tpls_mod_unit and tpls_value_mem
//
// Usage: one word goes in on the item channel and exactly one result word comes
// out on the result channel for it, in order. An init word checks and records a
// track layout and zeroes the track's bytes; a write stores one byte; a read
// returns one byte. Items are handled one at a time.
// Path through the sequencer: kind 3 and early rejects go from the check state
// straight to the response; writes and reads wait for the remainder unit that
// reduces the step, then form, add and check the index, and a read also passes
// the read wait state for the registered memory data; an init goes through the
// layout multiply and compare and, if accepted, clears the track, one memory word per cycle.
// The next item can be accepted in the same cycle that the result becomes valid.
// After reset the block clears all NUM_TRACKS * BYTES_PER_TRACK memory words
// with item_stall high; layouts come back as 128 steps, 8 layers, 1 instrument.
// The result register lets the next item be accepted while a result waits under
// result_stall; the block then holds its finished result until the register frees.
module track_parameter_layer_store_top #(
  parameter int NUM_TRACKS      = 16,
  parameter int BYTES_PER_TRACK = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  tpls_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output tpls_pkg::result_t result
);

  localparam int DEPTH = NUM_TRACKS * BYTES_PER_TRACK;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;
  localparam int BW    = $clog2(BYTES_PER_TRACK);
  localparam int SW    = tpls_pkg::STEP_W;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b000000000001,
    S_WIPE    = 12'b000000000010,
    S_CHECK   = 12'b000000000100,
    S_LAY_MUL = 12'b000000001000,
    S_LAY_CMP = 12'b000000010000,
    S_CLEAR   = 12'b000000100000,
    S_DIV     = 12'b000001000000,
    S_IDX_MUL = 12'b000010000000,
    S_IDX_ADD = 12'b000100000000,
    S_IDX_CHK = 12'b001000000000,
    S_RD_WAIT = 12'b010000000000,
    S_RESP    = 12'b100000000000
  } state_t;

  state_t state;
  tpls_pkg::item_t req;

  logic [SW-1:0] steps_tab  [NUM_TRACKS];
  logic [7:0]    layers_tab [NUM_TRACKS];
  logic [7:0]    insts_tab  [NUM_TRACKS];

  logic [6:0]    track_ext;
  logic          track_ok;
  logic [TW-1:0] tidx;
  logic [SW-1:0] cur_steps;
  logic [7:0]    cur_layers;
  logic [7:0]    cur_insts;

  logic [16:0]   il;
  logic [AW-1:0] base;
  logic [23:0]   lay_prod1;
  logic [31:0]   lay_prod2;
  logic [32:0]   idx_prod;
  logic [33:0]   idx_sum;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] clr_end;
  logic [AW-1:0] acc_addr;
  logic          idx_ok;

  logic [7:0]                  res_data;
  logic [tpls_pkg::STAT_W-1:0] res_status;

  logic          div_start;
  logic          div_done;
  logic [SW-1:0] div_rem;

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_rdata;

  logic          out_free;

  assign track_ext  = 7'(req.track);
  assign track_ok   = track_ext < 7'(NUM_TRACKS);
  assign tidx       = track_ok ? track_ext[TW-1:0] : '0;
  assign cur_steps  = steps_tab[tidx];
  assign cur_layers = layers_tab[tidx];
  assign cur_insts  = insts_tab[tidx];
  assign acc_addr   = base + AW'(idx_sum[BW-1:0]);
  assign idx_ok     = idx_sum < 34'(BYTES_PER_TRACK);
  assign out_free   = !result_valid || !result_stall;
  assign item_stall = (state != S_IDLE);

  assign div_start = (state == S_CHECK) && track_ok && (cur_steps != '0) &&
                     ((req.kind == tpls_pkg::KIND_READ) ||
                      ((req.kind == tpls_pkg::KIND_WRITE) &&
                       (req.instrument_index < cur_insts) &&
                       (req.layer_index < cur_layers)));

  always_comb begin
    mem_we   = 1'b0;
    mem_addr = acc_addr;
    if ((state == S_WIPE) || (state == S_CLEAR)) begin
      mem_we   = 1'b1;
      mem_addr = clr_addr;
    end else if (state == S_IDX_CHK) begin
      mem_we = idx_ok && (req.kind == tpls_pkg::KIND_WRITE);
    end
  end

  tpls_mod_unit u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (req.step_number),
    .divisor   (cur_steps),
    .done      (div_done),
    .remainder (div_rem)
  );

  tpls_value_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata ((mem_we && (state == S_IDX_CHK)) ? req.write_value : 8'd0),
    .rdata (mem_rdata)
  );

  // control and layout tables
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_WIPE;
      clr_addr     <= '0;
      clr_end      <= AW'(DEPTH - 1);
      result_valid <= 1'b0;
      for (int i = 0; i < NUM_TRACKS; i++) begin
        steps_tab[i]  <= tpls_pkg::RESET_STEPS;
        layers_tab[i] <= tpls_pkg::RESET_LAYERS;
        insts_tab[i]  <= tpls_pkg::RESET_INSTRUMENTS;
      end
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            state <= S_CHECK;
          end
        end
        S_WIPE: begin
          if (clr_addr == clr_end) begin
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        S_CHECK: begin
          unique case (req.kind)
            tpls_pkg::KIND_INIT: begin
              if (!track_ok || (req.layout_steps == '0)) begin
                state <= S_RESP;
              end else begin
                state <= S_LAY_MUL;
              end
            end
            tpls_pkg::KIND_WRITE, tpls_pkg::KIND_READ: begin
              state <= div_start ? S_DIV : S_RESP;
            end
            default: state <= S_RESP;
          endcase
        end
        S_LAY_MUL: state <= S_LAY_CMP;
        S_LAY_CMP: begin
          if (lay_prod2 > 32'(BYTES_PER_TRACK)) begin
            state <= S_RESP;
          end else begin
            steps_tab[tidx]  <= req.layout_steps;
            layers_tab[tidx] <= req.layout_layers;
            insts_tab[tidx]  <= req.layout_instruments;
            clr_addr         <= base;
            clr_end          <= base + AW'(BYTES_PER_TRACK - 1);
            state            <= S_CLEAR;
          end
        end
        S_CLEAR: begin
          if (clr_addr == clr_end) begin
            state <= S_RESP;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_IDX_MUL;
          end
        end
        S_IDX_MUL: state <= S_IDX_ADD;
        S_IDX_ADD: state <= S_IDX_CHK;
        S_IDX_CHK: begin
          state <= (idx_ok && (req.kind == tpls_pkg::KIND_READ)) ? S_RD_WAIT : S_RESP;
        end
        S_RD_WAIT: state <= S_RESP;
        S_RESP: begin
          if (out_free) begin
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        req        <= item;
        res_data   <= 8'd0;
        res_status <= tpls_pkg::ST_OK;
      end
      S_CHECK: begin
        il        <= 17'(16'(req.instrument_index) * 16'(cur_layers)) + 17'(req.layer_index);
        base      <= AW'(AW'(tidx) * AW'(BYTES_PER_TRACK));
        lay_prod1 <= 24'(req.layout_steps) * 24'(req.layout_layers);
        unique case (req.kind)
          tpls_pkg::KIND_INIT: begin
            if (!track_ok || (req.layout_steps == '0)) begin
              res_status <= tpls_pkg::ST_BAD_LAYOUT;
            end
          end
          tpls_pkg::KIND_WRITE: begin
            if (!track_ok) begin
              res_status <= tpls_pkg::ST_BAD_STEP;
            end else if (req.instrument_index >= cur_insts) begin
              res_status <= tpls_pkg::ST_BAD_INSTRUMENT;
            end else if (req.layer_index >= cur_layers) begin
              res_status <= tpls_pkg::ST_BAD_LAYER;
            end else if (cur_steps == '0) begin
              res_status <= tpls_pkg::ST_BAD_STEP;
            end
          end
          tpls_pkg::KIND_READ: begin
            if (!track_ok || (cur_steps == '0)) begin
              res_status <= tpls_pkg::ST_BAD_STEP;
            end
          end
          default: res_status <= tpls_pkg::ST_OK;
        endcase
      end
      S_LAY_MUL: lay_prod2 <= 32'(lay_prod1) * 32'(req.layout_instruments);
      S_LAY_CMP: begin
        if (lay_prod2 > 32'(BYTES_PER_TRACK)) begin
          res_status <= tpls_pkg::ST_BAD_LAYOUT;
        end
      end
      S_IDX_MUL: idx_prod <= 33'(il) * 33'(cur_steps);
      S_IDX_ADD: idx_sum  <= 34'(idx_prod) + 34'(div_rem);
      S_IDX_CHK: begin
        if (!idx_ok) begin
          res_status <= tpls_pkg::ST_BAD_STEP;
        end
      end
      S_RD_WAIT: res_data <= mem_rdata;
      S_RESP: begin
        if (out_free) begin
          result.read_data <= res_data;
          result.status    <= res_status;
        end
      end
      default: begin
      end
    endcase
  end

  a_store_only_on_good_write: assert property (@(posedge clk) disable iff (rst)
    (mem_we && (state == S_IDX_CHK)) |->
      ((req.kind == tpls_pkg::KIND_WRITE) && (res_status == tpls_pkg::ST_OK)))
    else $error("store written by an item that is not a valid write");

  a_remainder_only_when_waiting: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("remainder unit finished outside its wait state");

  a_error_reads_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status != tpls_pkg::ST_OK)) |-> (result.read_data == 8'd0))
    else $error("failed item returned nonzero data");

  a_clear_ends_in_response: assert property (@(posedge clk) disable iff (rst)
    ((state == S_CLEAR) && (clr_addr == clr_end)) |=> (state == S_RESP))
    else $error("track clear did not finish with a response");

endmodule

@@ verif/track_parameter_layer_store_top_test.sv @@
// testbench of track_parameter_layer_store_top: a directed table, then random words in phases
// of sender idling and receiver stalling, results checked by the table or a store model
// depends on tpls_pkg and the rtl of track_parameter_layer_store_top
module track_parameter_layer_store_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_TRACKS       = 16;
  localparam int BYTES_PER_TRACK  = 1024;
  localparam int WORDS_PER_PHASE  = 332;
  localparam int CYCLE_LIMIT      = 8000000;

  typedef struct {
    tpls_pkg::item_t   word;
    bit                typed;
    tpls_pkg::result_t want;
  } row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_stall;
  tpls_pkg::item_t   item = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  tpls_pkg::result_t result;

  // local copy of the layouts and of the byte store
  logic [tpls_pkg::STEP_W-1:0] steps_tab  [NUM_TRACKS];
  logic [tpls_pkg::BYTE_W-1:0] layers_tab [NUM_TRACKS];
  logic [tpls_pkg::BYTE_W-1:0] insts_tab  [NUM_TRACKS];
  logic [tpls_pkg::BYTE_W-1:0] shadow_bytes [NUM_TRACKS*BYTES_PER_TRACK];

  tpls_pkg::result_t pending_results[$];
  tpls_pkg::item_t   recent_writes[$];
  row_t              directed_rows[$];
  int unsigned       mismatches = 0;
  int unsigned       cycles = 0;
  int unsigned       sender_idle_pct = 0;
  int unsigned       recv_stall_pct = 0;

  track_parameter_layer_store_top #(
    .NUM_TRACKS     (NUM_TRACKS),
    .BYTES_PER_TRACK(BYTES_PER_TRACK)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void reset_store_model();
    for (int t = 0; t < NUM_TRACKS; t++) begin
      steps_tab[t]  = tpls_pkg::RESET_STEPS;
      layers_tab[t] = tpls_pkg::RESET_LAYERS;
      insts_tab[t]  = tpls_pkg::RESET_INSTRUMENTS;
    end
    for (int i = 0; i < NUM_TRACKS*BYTES_PER_TRACK; i++) shadow_bytes[i] = '0;
  endfunction

  // result of one word, updating layouts and bytes as the block would
  function automatic tpls_pkg::result_t predict_layer_store(input tpls_pkg::item_t w);
    tpls_pkg::result_t r;
    longint unsigned   ns;
    longint unsigned   nl;
    longint unsigned   idx;
    longint unsigned   size;
    bit                hit;
    int unsigned       base;
    r    = '0;
    hit  = 1'b0;
    idx  = 0;
    base = w.track * BYTES_PER_TRACK;
    ns   = 64'(steps_tab[w.track]);
    nl   = 64'(layers_tab[w.track]);
    if (ns != 0) begin
      idx = 64'(w.instrument_index) * nl * ns + 64'(w.layer_index) * ns
          + 64'(w.step_number) % ns;
      hit = idx < BYTES_PER_TRACK;
    end
    case (w.kind)
      tpls_pkg::KIND_INIT: begin
        size = 64'(w.layout_steps) * w.layout_layers * w.layout_instruments;
        if (w.track >= NUM_TRACKS || w.layout_steps == 0 || size > BYTES_PER_TRACK) begin
          r.status = tpls_pkg::ST_BAD_LAYOUT;
        end else begin
          steps_tab[w.track]  = w.layout_steps;
          layers_tab[w.track] = w.layout_layers;
          insts_tab[w.track]  = w.layout_instruments;
          for (int i = 0; i < BYTES_PER_TRACK; i++) shadow_bytes[base + i] = '0;
        end
      end
      tpls_pkg::KIND_WRITE: begin
        if (w.track >= NUM_TRACKS) begin
          r.status = tpls_pkg::ST_BAD_STEP;
        end else if (w.instrument_index >= insts_tab[w.track]) begin
          r.status = tpls_pkg::ST_BAD_INSTRUMENT;
        end else if (w.layer_index >= layers_tab[w.track]) begin
          r.status = tpls_pkg::ST_BAD_LAYER;
        end else if (hit) begin
          shadow_bytes[base + int'(idx)] = w.write_value;
        end else begin
          r.status = tpls_pkg::ST_BAD_STEP;
        end
      end
      tpls_pkg::KIND_READ: begin
        if (w.track >= NUM_TRACKS || !hit) begin
          r.status = tpls_pkg::ST_BAD_STEP;
        end else begin
          r.read_data = shadow_bytes[base + int'(idx)];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic tpls_pkg::item_t make_item(input logic [tpls_pkg::KIND_W-1:0] kind,
                                      input int unsigned track, input int unsigned step,
                                      input int unsigned layer, input int unsigned inst,
                                      input int unsigned value, input int unsigned lsteps,
                                      input int unsigned llayers, input int unsigned linsts);
    tpls_pkg::item_t w;
    w.kind               = kind;
    w.track              = 4'(track);
    w.step_number        = 16'(step);
    w.layer_index        = 8'(layer);
    w.instrument_index   = 8'(inst);
    w.write_value        = 8'(value);
    w.layout_steps       = 16'(lsteps);
    w.layout_layers      = 8'(llayers);
    w.layout_instruments = 8'(linsts);
    return w;
  endfunction

  function automatic void add_row(input tpls_pkg::item_t w, input bit typed,
                                  input logic [tpls_pkg::BYTE_W-1:0] data,
                                  input logic [tpls_pkg::STAT_W-1:0] st);
    row_t r;
    r.word           = w;
    r.typed          = typed;
    r.want.read_data = data;
    r.want.status    = st;
    directed_rows.push_back(r);
  endfunction

  // mostly addresses inside the current layout, reads often hit recent writes
  function automatic tpls_pkg::item_t random_item();
    tpls_pkg::item_t              w;
    int unsigned                  roll;
    int unsigned                  room;
    int unsigned                  pick;
    logic [tpls_pkg::TRACK_W-1:0] t;
    w.kind               = 2'($urandom_range(3));
    w.track              = 4'($urandom_range(NUM_TRACKS - 1));
    w.step_number        = 16'($urandom_range(16'hffff));
    w.layer_index        = 8'($urandom_range(255));
    w.instrument_index   = 8'($urandom_range(255));
    w.write_value        = 8'($urandom_range(255));
    w.layout_steps       = 16'($urandom_range(16'hffff));
    w.layout_layers      = 8'($urandom_range(255));
    w.layout_instruments = 8'($urandom_range(255));
    roll = $urandom_range(99);
    if (roll < 6) begin
      w.kind = tpls_pkg::KIND_INIT;
      if ($urandom_range(9) < 6) begin
        w.layout_steps = 16'(($urandom_range(9) == 0) ? $urandom_range(1, BYTES_PER_TRACK)
                                                      : $urandom_range(1, 32));
        room = BYTES_PER_TRACK / w.layout_steps;
        w.layout_layers = 8'($urandom_range(0, room > 255 ? 255 : room));
        room = (w.layout_layers != 0) ? room / w.layout_layers : 255;
        w.layout_instruments = 8'($urandom_range(0, room > 255 ? 255 : room));
      end
    end else if (roll < 9) begin
      w.kind = tpls_pkg::KIND_NONE;
    end else begin
      w.kind = (roll < 54) ? tpls_pkg::KIND_WRITE : tpls_pkg::KIND_READ;
      if ($urandom_range(4) != 0) begin
        if (w.kind == tpls_pkg::KIND_READ && recent_writes.size() != 0 &&
            $urandom_range(1) == 1) begin
          pick               = $urandom_range(recent_writes.size() - 1);
          w.track            = recent_writes[pick].track;
          w.step_number      = recent_writes[pick].step_number;
          w.layer_index      = recent_writes[pick].layer_index;
          w.instrument_index = recent_writes[pick].instrument_index;
        end else begin
          t = w.track;
          if (insts_tab[t] != 0) w.instrument_index = 8'($urandom_range(insts_tab[t] - 1));
          if (layers_tab[t] != 0) w.layer_index = 8'($urandom_range(layers_tab[t] - 1));
          if ($urandom_range(1) == 1) w.step_number = 16'($urandom_range(steps_tab[t] - 1));
        end
        if (w.kind == tpls_pkg::KIND_WRITE) begin
          recent_writes.push_back(w);
          if (recent_writes.size() > 16) void'(recent_writes.pop_front());
        end
      end
    end
    return w;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic push_item(input tpls_pkg::item_t w, input bit typed,
                           input tpls_pkg::result_t want);
    tpls_pkg::result_t got;
    while ($urandom_range(99) < sender_idle_pct) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item_valid = 1'b1;
    item       = w;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    got = predict_layer_store(w);
    pending_results.push_back(typed ? want : got);
    @(negedge clk);
  endtask

  // called at a falling edge, returns at a rising edge with nothing pending
  task automatic wait_drain();
    item_valid = 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    result_stall = ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    tpls_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("result word with nothing pending: data %0h status %0d",
                   result.read_data, result.status);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (result.read_data !== want.read_data || result.status !== want.status) begin
          if (mismatches < 10)
            $display("mismatch: read_data exp %0h got %0h, status exp %0d got %0d",
                     want.read_data, result.read_data, want.status, result.status);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    reset_store_model();
    // reset layout is 128 steps, 8 layers, 1 instrument: exactly one full track
    add_row(make_item(tpls_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
            8'h00, tpls_pkg::ST_OK);
    add_row(make_item(tpls_pkg::KIND_WRITE, 0, 16'hffff, 7, 0, 8'hff, 0, 0, 0), 1'b1,
            8'h00, tpls_pkg::ST_OK);
    add_row(make_item(tpls_pkg::KIND_READ, 0, 16'hffff, 7, 0, 0, 0, 0, 0), 1'b1,
            8'hff, tpls_pkg::ST_OK);
    add_row(make_item(tpls_pkg::KIND_WRITE, 0, 0, 0, 1, 8'h12, 0, 0, 0), 1'b1,
            8'h00, tpls_pkg::ST_BAD_INSTRUMENT);
    add_row(make_item(tpls_pkg::KIND_WRITE, 0, 0, 8, 0, 8'h34, 0, 0, 0), 1'b1,
            8'h00, tpls_pkg::ST_BAD_LAYER);
    add_row(make_item(tpls_pkg::KIND_WRITE, 0, 0, 255, 255, 8'h56, 0, 0, 0), 1'b1,
            8'h00, tpls_pkg::ST_BAD_INSTRUMENT);
    add_row(make_item(tpls_pkg::KIND_READ, 0, 0, 8, 0, 0, 0, 0, 0), 1'b1,
            8'h00, tpls_pkg::ST_BAD_STEP);
    add_row(make_item(tpls_pkg::KIND_READ, 0, 16'hffff, 255, 255, 0, 0, 0, 0), 1'b1,
            8'h00, tpls_pkg::ST_BAD_STEP);
    // small layout: reads with bad instrument or layer still land inside the track
    add_row(make_item(tpls_pkg::KIND_INIT, 1, 0, 0, 0, 0, 4, 2, 2), 1'b1,
            8'h00, tpls_pkg::ST_OK);
    add_row(make_item(tpls_pkg::KIND_READ, 1, 0, 0, 2, 0, 0, 0, 0), 1'b1,
            8'h00, tpls_pkg::ST_OK);
    add_row(make_item(tpls_pkg::KIND_READ, 1, 3, 5, 0, 0, 0, 0, 0), 1'b1,
            8'h00, tpls_pkg::ST_OK);
    add_row(make_item(tpls_pkg::KIND_WRITE, 1, 5, 1, 1, 8'h3c, 0, 0, 0), 1'b0,
            8'h00, tpls_pkg::ST_OK);
    add_row(make_item(tpls_pkg::KIND_READ, 1, 1, 1, 1, 0, 0, 0, 0), 1'b0,
            8'h00, tpls_pkg::ST_OK);
    // layout checks: zero steps, too large, one past the limit, exactly the limit
    add_row(make_item(tpls_pkg::KIND_INIT, 2, 0, 0, 0, 0, 0, 1, 1), 1'b1,
            8'h00, tpls_pkg::ST_BAD_LAYOUT);
    add_row(make_item(tpls_pkg::KIND_INIT, 2, 0, 0, 0, 0, 16'hffff, 255, 255), 1'b1,
            8'h00, tpls_pkg::ST_BAD_LAYOUT);
    add_row(make_item(tpls_pkg::KIND_INIT, 2, 0, 0, 0, 0, 1025, 1, 1), 1'b1,
            8'h00, tpls_pkg::ST_BAD_LAYOUT);
    add_row(make_item(tpls_pkg::KIND_INIT, 2, 0, 0, 0, 0, 1024, 1, 1), 1'b1,
            8'h00, tpls_pkg::ST_OK);
    add_row(make_item(tpls_pkg::KIND_WRITE, 2, 1023, 0, 0, 8'h81, 0, 0, 0), 1'b0,
            8'h00, tpls_pkg::ST_OK);
    // zero layers, zero instruments
    add_row(make_item(tpls_pkg::KIND_INIT, 3, 0, 0, 0, 0, 7, 0, 5), 1'b1,
            8'h00, tpls_pkg::ST_OK);
    add_row(make_item(tpls_pkg::KIND_WRITE, 3, 0, 0, 0, 8'h77, 0, 0, 0), 1'b1,
            8'h00, tpls_pkg::ST_BAD_LAYER);
    add_row(make_item(tpls_pkg::KIND_READ, 3, 100, 0, 0, 0, 0, 0, 0), 1'b1,
            8'h00, tpls_pkg::ST_OK);
    add_row(make_item(tpls_pkg::KIND_INIT, 4, 0, 0, 0, 0, 3, 3, 0), 1'b1,
            8'h00, tpls_pkg::ST_OK);
    add_row(make_item(tpls_pkg::KIND_WRITE, 4, 0, 0, 0, 8'h99, 0, 0, 0), 1'b1,
            8'h00, tpls_pkg::ST_BAD_INSTRUMENT);
    // unused kind, then re-init clears the byte written earlier
    add_row(make_item(tpls_pkg::KIND_NONE, 15, 16'hffff, 255, 255, 255, 16'hffff, 255, 255),
            1'b1, 8'h00, tpls_pkg::ST_OK);
    add_row(make_item(tpls_pkg::KIND_INIT, 0, 0, 0, 0, 0, 1024, 1, 1), 1'b1,
            8'h00, tpls_pkg::ST_OK);
    add_row(make_item(tpls_pkg::KIND_READ, 0, 1023, 0, 0, 0, 0, 0, 0), 1'b1,
            8'h00, tpls_pkg::ST_OK);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i])
      push_item(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);

    for (int phase = 0; phase < 4; phase++) begin
      wait_drain();
      case (phase)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin sender_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      @(negedge clk);
      repeat (WORDS_PER_PHASE) push_item(random_item(), 1'b0, '0);
    end

    wait_drain();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
